// File: rtl/core/fmm_pkg.sv
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared widths and constants for the p25519 field multiplier.
// ----------------------------------------------------------------------------
package fmm_pkg;

  localparam int unsigned LimbW   = 32;
  localparam int unsigned NumLimb = 8;
  localparam int unsigned OpW     = 256;
  localparam int unsigned ColW    = 36;
  localparam int unsigned FoldW   = 262;
  localparam int unsigned Latency = 6;

  localparam logic [5:0] FoldHi  = 6'd38;
  localparam logic [4:0] FoldTop = 5'd19;

endpackage

// File: rtl/core/fmm_mul.sv
// ----------------------------------------------------------------------------
// fmm_mul
// Three-stage 256x256 multiplier: limb products, column sums, final carry add.
// ----------------------------------------------------------------------------
module fmm_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [fmm_pkg::OpW-1:0]     a_i,
  input  logic [fmm_pkg::OpW-1:0]     b_i,
  output logic                        valid_o,
  output logic [2*fmm_pkg::OpW-1:0]   prod_o
);

  localparam int unsigned NL = fmm_pkg::NumLimb;
  localparam int unsigned LW = fmm_pkg::LimbW;
  localparam int unsigned CW = fmm_pkg::ColW;
  localparam int unsigned PW = 2 * fmm_pkg::OpW;

  logic [2*LW-1:0] pp_q [NL][NL];
  logic [CW-1:0]   col_d [2*NL];
  logic [CW-1:0]   col_q [2*NL];
  logic [PW-1:0]   sum_a, sum_b;
  logic [PW-1:0]   prod_q;
  logic [2:0]      vld_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp_q[i][j] <= {{LW{1'b0}}, a_i[LW*i +: LW]} * {{LW{1'b0}}, b_i[LW*j +: LW]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2*NL; k++) begin
      col_d[k] = '0;
    end
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        col_d[i+j]   = col_d[i+j]   + CW'(pp_q[i][j][LW-1:0]);
        col_d[i+j+1] = col_d[i+j+1] + CW'(pp_q[i][j][2*LW-1:LW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int k = 0; k < 2*NL; k++) begin
      sum_a[LW*k +: LW] = col_q[k][LW-1:0];
    end
    for (int k = 0; k < 2*NL-1; k++) begin
      sum_b[LW*(k+1) +: CW-LW] = col_q[k][CW-1:LW];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sum_a + sum_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign prod_o  = prod_q;

endmodule

// File: rtl/core/fmm_red.sv
// ----------------------------------------------------------------------------
// fmm_red
// Three-stage reduction of a 512-bit product modulo 2^255-19.
// ----------------------------------------------------------------------------
module fmm_red (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [2*fmm_pkg::OpW-1:0]   prod_i,
  output logic                        valid_o,
  output logic [fmm_pkg::OpW-2:0]     res_o
);

  localparam int unsigned OW = fmm_pkg::OpW;
  localparam int unsigned FW = fmm_pkg::FoldW;
  localparam int unsigned TW = 12;

  logic [OW-1:0] hi, lo;
  logic [FW-1:0] fold_q;
  logic [TW-1:0] top_add;
  logic [OW-1:0] red_q;
  logic [OW-1:0] trial;
  logic [OW-2:0] res_q;
  logic [2:0]    vld_q;

  assign lo = prod_i[OW-1:0];
  assign hi = prod_i[2*OW-1:OW];

  // low + 38*high, 38 = 32 + 4 + 2
  always_ff @(posedge clk_i) begin
    fold_q <= FW'(lo) + FW'({hi, 5'b0}) + FW'({hi, 2'b0}) + FW'({hi, 1'b0});
  end

  // carry above bit 255 is at most 63, so 63*38+19 fits in TW bits
  assign top_add = TW'(fold_q[FW-1:OW]) * TW'(fmm_pkg::FoldHi)
                 + (fold_q[OW-1] ? TW'(fmm_pkg::FoldTop) : '0);

  always_ff @(posedge clk_i) begin
    red_q <= OW'(fold_q[OW-2:0]) + OW'(top_add);
  end

  assign trial = red_q + OW'(fmm_pkg::FoldTop);

  always_ff @(posedge clk_i) begin
    res_q <= trial[OW-1] ? trial[OW-2:0] : red_q[OW-2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = res_q;

endmodule

// File: rtl/core/field_mul_mod_p25519_top.sv
// ----------------------------------------------------------------------------
// field_mul_mod_p25519_top
// Pipelined multiplier a*b mod 2^255-19 on 256-bit operands.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the eight operand words and raise start for one cycle per item.
//   busy is always low, so a transfer happens at every edge with start high;
//   a new item may enter in every cycle.
//   The result appears on prod_word*_o with done_o high for one cycle, once
//   the item has passed the pipeline stages (three multiplier stages: limb
//   products, column sums, carry add; three reduction stages: fold by 38,
//   fold of bit 255 and carry, trial subtraction of p).
//   Throughput: one item per cycle. Results are fully reduced into 0..p-1.
//   The receiver cannot stall; results are shown once.
//   Reset clears the valid bits only; items in flight are dropped.
// ----------------------------------------------------------------------------
module field_mul_mod_p25519_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] a_word0_i,
  input  logic [63:0] a_word1_i,
  input  logic [63:0] a_word2_i,
  input  logic [63:0] a_word3_i,
  input  logic [63:0] b_word0_i,
  input  logic [63:0] b_word1_i,
  input  logic [63:0] b_word2_i,
  input  logic [63:0] b_word3_i,
  output logic        done_o,
  output logic [63:0] prod_word0_o,
  output logic [63:0] prod_word1_o,
  output logic [63:0] prod_word2_o,
  output logic [62:0] prod_word3_o
);

  logic                          mul_vld;
  logic [2*fmm_pkg::OpW-1:0]     mul_prod;
  logic [fmm_pkg::OpW-2:0]       res;

  assign busy = 1'b0;

  fmm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .a_i     ({a_word3_i, a_word2_i, a_word1_i, a_word0_i}),
    .b_i     ({b_word3_i, b_word2_i, b_word1_i, b_word0_i}),
    .valid_o (mul_vld),
    .prod_o  (mul_prod)
  );

  fmm_red u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_vld),
    .prod_i  (mul_prod),
    .valid_o (done_o),
    .res_o   (res)
  );

  assign prod_word0_o = res[63:0];
  assign prod_word1_o = res[127:64];
  assign prod_word2_o = res[191:128];
  assign prod_word3_o = res[254:192];

endmodule

// File: rtl/core/fmm_checker.sv
// ----------------------------------------------------------------------------
// fmm_checker
// Port-level checks of the field multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module fmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [63:0] prod_word0_o,
  input logic [63:0] prod_word1_o,
  input logic [63:0] prod_word2_o,
  input logic [62:0] prod_word3_o
);

  logic [2:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q != 3'(fmm_pkg::Latency)) begin
      age_q <= age_q + 3'd1;
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q == 3'(fmm_pkg::Latency)) |->
      (done_o == $past(start && !busy, fmm_pkg::Latency)))
    else $error("done does not follow start by pipeline latency");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q != 3'(fmm_pkg::Latency)) |-> !done_o)
    else $error("done without a transfer");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (&prod_word3_o) && (&prod_word2_o) && (&prod_word1_o)) |->
      (prod_word0_o < 64'hFFFF_FFFF_FFFF_FFED))
    else $error("result not below p");

endmodule

bind field_mul_mod_p25519_top fmm_checker u_fmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .prod_word0_o (prod_word0_o),
  .prod_word1_o (prod_word1_o),
  .prod_word2_o (prod_word2_o),
  .prod_word3_o (prod_word3_o)
);

// File: dv/tb_field_mul_mod_p25519_top.sv
// ----------------------------------------------------------------------------
// tb_field_mul_mod_p25519_top
// Self-checking bench for the p25519 field multiplier. A directed table
// (zeros, ones, all-ones operands, values at and above p, products that are
// multiples of p) is followed by random operands with random start gaps.
// Every result is compared as a whole against a table value or an in-bench modular model.
// ----------------------------------------------------------------------------
module tb_field_mul_mod_p25519_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRand  = 1300;
  localparam int unsigned CycLimit = 200000;

  typedef struct packed {
    logic [255:0] a;
    logic [255:0] b;
    logic         known;
    logic [254:0] prod;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] a_w [4];
  logic [63:0] b_w [4];
  logic        done_o;
  logic [63:0] prod_word0_o, prod_word1_o, prod_word2_o;
  logic [62:0] prod_word3_o;

  logic [254:0] prod_q [$];
  row_t         rows [$];
  int unsigned  errors, n_items, n_results, cycles;

  localparam logic [255:0] P = (256'd1 << 255) - 256'd19;

  field_mul_mod_p25519_top dut (
    .clk_i, .rst_ni, .start, .busy,
    .a_word0_i(a_w[0]), .a_word1_i(a_w[1]), .a_word2_i(a_w[2]), .a_word3_i(a_w[3]),
    .b_word0_i(b_w[0]), .b_word1_i(b_w[1]), .b_word2_i(b_w[2]), .b_word3_i(b_w[3]),
    .done_o, .prod_word0_o, .prod_word1_o, .prod_word2_o, .prod_word3_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic [254:0] mulmod_p(logic [255:0] x, logic [255:0] y);
    logic [511:0] full;
    full = 512'(x) * 512'(y);
    return 255'(full % 512'(P));
  endfunction

  function automatic logic [255:0] rand256();
    logic [255:0] v;
    int unsigned  k;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    k = $urandom_range(0, 9);
    if (k == 0) v = P + 256'($urandom_range(0, 40));
    else if (k == 1) v = '1 - 256'($urandom_range(0, 40));
    else if (k == 2) v = 256'($urandom_range(0, 40));
    else if (k == 3) v = P - 256'($urandom_range(1, 40));
    return v;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("%0t timeout", $realtime);
      $display("field_mul_mod_p25519_top regression: fail");
      $finish;
    end
    if (rst_ni && done_o) begin
      n_results <= n_results + 1;
      if (prod_q.size() == 0) begin
        $display("%0t unexpected result %h", $realtime,
                 {prod_word3_o, prod_word2_o, prod_word1_o, prod_word0_o});
        errors <= errors + 1;
      end else begin
        logic [254:0] e;
        e = prod_q.pop_front();
        if ({prod_word3_o, prod_word2_o, prod_word1_o, prod_word0_o} !== e) begin
          $display("%0t mismatch exp %h got %h", $realtime, e,
                   {prod_word3_o, prod_word2_o, prod_word1_o, prod_word0_o});
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic send(logic [255:0] x, logic [255:0] y, logic [254:0] e, bit idle);
    int unsigned g;
    if (idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      g = $urandom_range(1, 4);
      repeat (g) @(posedge clk_i);
    end
    for (int i = 0; i < 4; i++) begin
      a_w[i] <= x[i*64 +: 64];
      b_w[i] <= y[i*64 +: 64];
    end
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    prod_q.push_back(e);
    n_items++;
  endtask

  initial begin
    row_t r;
    logic [255:0] x, y;
    int unsigned  w;
    errors = 0; n_items = 0; n_results = 0; cycles = 0;
    start = 1'b0;
    for (int i = 0; i < 4; i++) begin a_w[i] = '0; b_w[i] = '0; end
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{256'd0, 256'd0, 1'b1, 255'd0});
    rows.push_back('{256'd1, 256'd1, 1'b1, 255'd1});
    rows.push_back('{'1, 256'd0, 1'b1, 255'd0});
    rows.push_back('{P, 256'd5, 1'b1, 255'd0});
    rows.push_back('{P, P, 1'b1, 255'd0});
    rows.push_back('{P + 256'd1, 256'd7, 1'b1, 255'd7});
    rows.push_back('{P - 256'd1, P - 256'd1, 1'b1, 255'd1});
    rows.push_back('{P - 256'd1, 256'd1, 1'b1, 255'(P - 256'd1)});
    rows.push_back('{'1, '1, 1'b0, '0});
    rows.push_back('{'1, 256'd1, 1'b0, '0});
    rows.push_back('{256'd1 << 255, 256'd2, 1'b0, '0});
    rows.push_back('{256'd1 << 128, 256'd1 << 128, 1'b1, 255'd38});
    rows.push_back('{{4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}}, 1'b0, '0});
    rows.push_back('{{4{64'h5555_5555_5555_5555}}, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b0, '0});
    rows.push_back('{2 * P, 256'd3, 1'b1, 255'd0});
    foreach (rows[i]) begin
      r = rows[i];
      send(r.a, r.b, r.known ? r.prod : mulmod_p(r.a, r.b), 1'b1);
    end

    for (int i = 0; i < NumRand; i++) begin
      x = rand256();
      y = rand256();
      send(x, y, mulmod_p(x, y), i < NumRand - 200);
    end
    start <= 1'b0;

    w = 0;
    while (prod_q.size() != 0 && w < 1000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (fmm_pkg::Latency + 4) @(posedge clk_i);
    $display("%0d products sent, %0d results checked, directed and random operands",
             n_items, n_results);
    if (errors == 0 && prod_q.size() == 0) begin
      $display("field_mul_mod_p25519_top regression: pass");
    end else begin
      $display("field_mul_mod_p25519_top regression: fail");
    end
    $finish;
  end
endmodule
